>>> design/tapa_pkg.sv
// Shared constants, types and helpers of the tensor axis permute addresser.
package tapa_pkg;

   localparam int MAX_RANK       = 5;
   localparam int ADDR_BITS      = 24;
   localparam int DIM_BITS       = 16;
   localparam int AXIS_BITS      = 3;
   localparam int RANK_BITS      = 3;
   localparam int ORDER_BITS     = AXIS_BITS * MAX_RANK;
   localparam int NUM_DIM_REGS   = 5;
   localparam int LVL_BITS       = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int RCNT_BITS      = $clog2(MAX_RANK + 1);
   localparam int PROD_BITS      = ADDR_BITS + 1;
   localparam int MAC_BITS       = PROD_BITS + DIM_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = (DIM_BITS > ORDER_BITS) ? DIM_BITS : ORDER_BITS;

   typedef logic [ADDR_BITS-1:0]      addr_type;
   typedef logic [DIM_BITS-1:0]       dim_type;
   typedef logic [AXIS_BITS-1:0]      axis_type;
   typedef logic [LVL_BITS-1:0]       lvl_type;
   typedef logic [RCNT_BITS-1:0]      rcnt_type;
   typedef logic [PROD_BITS-1:0]      prod_type;
   typedef logic [MAC_BITS-1:0]       mac_word_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   localparam csr_index_type REG_RANK  = csr_index_type'(0);
   localparam csr_index_type REG_DIM_0 = csr_index_type'(1);
   localparam csr_index_type REG_ORDER = csr_index_type'(6);

   localparam prod_type ADDR_LIMIT = prod_type'(1) << ADDR_BITS;
   localparam prod_type PROD_CLAMP = ADDR_LIMIT + prod_type'(1);

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_PERM  = 2'd1,
      ERR_RANGE = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STRIDE,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic [RANK_BITS-1:0]               rank;
      logic [MAX_RANK-1:0][DIM_BITS-1:0]  dim;
      logic [ORDER_BITS-1:0]              order;
   } cfg_type;

   typedef struct packed {
      prod_type a;
      dim_type  b;
      addr_type c;
   } mac_op_type;

   function automatic dim_type eff_dim(input dim_type d);
      return (d == '0) ? dim_type'(1) : d;
   endfunction

   function automatic cfg_type cfg_reset();
      cfg_type c;
      c.rank = RANK_BITS'(1);
      for (int k = 0; k < MAX_RANK; k++) begin
         c.dim[k] = dim_type'(1);
         c.order[AXIS_BITS*k +: AXIS_BITS] = axis_type'(k);
      end
      return c;
   endfunction

endpackage

>>> design/tensor_axis_permute_addresser_unit.sv
// Top level: permuted-order source offset generator with a shared MAC sequencer.
// Restart: ST_STRIDE steps through the R levels, then a status beat is registered (R = effective rank).
// Advance in a pass: ST_SUM steps through the R levels, then the offset is registered.
// Advance with no pass active: result registered, valid in the cycle after accept.
// No new request is taken until the sequencer is idle again, as all steps share the single multiply-accumulate unit.
// Synchronous reset: rank 1, sizes 1, identity order, no pass active, no beat held.
module tensor_axis_permute_addresser_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_restart,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tapa_pkg::addr_type      rsp_source_offset,
   output logic                    rsp_last,
   output logic [1:0]              rsp_error_code,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  tapa_pkg::csr_index_type csr_index,
   input  tapa_pkg::csr_data_type  csr_data
);

   localparam int MR = tapa_pkg::MAX_RANK;

   tapa_pkg::cfg_type      cfg;
   tapa_pkg::mac_op_type   mac_op;
   tapa_pkg::mac_word_type mac_result;
   logic                   mac_over;

   tapa_pkg::state_type state_ff, state_in;
   tapa_pkg::lvl_type   lvl_ff, lvl_in;
   tapa_pkg::prod_type  prod_ff, prod_in;
   logic                over_ff, over_in;
   logic                bad_ff, bad_in;
   tapa_pkg::addr_type  acc_ff, acc_in;
   logic                last_acc_ff, last_acc_in;
   logic                pass_active_ff, pass_active_in;
   tapa_pkg::rcnt_type  lat_rank_ff, lat_rank_in;
   tapa_pkg::lvl_type   lat_axis_ff[MR], lat_axis_in[MR];
   tapa_pkg::dim_type   lat_len_ff[MR], lat_len_in[MR];
   tapa_pkg::dim_type   loop_index_ff[MR], loop_index_in[MR];
   tapa_pkg::addr_type  axis_stride_ff[MR], axis_stride_in[MR];
   logic                rsp_valid_ff, rsp_valid_in;
   tapa_pkg::addr_type  rsp_offset_ff, rsp_offset_in;
   logic                rsp_last_ff, rsp_last_in;
   tapa_pkg::err_type   rsp_err_ff, rsp_err_in;

   logic                out_free;
   logic                accept;
   tapa_pkg::rcnt_type  rank_eff;
   logic                bad_new;
   logic                first_last;
   tapa_pkg::lvl_type   axes_new[MR];
   tapa_pkg::dim_type   len_new[MR];
   tapa_pkg::dim_type   idx_step[MR];
   logic                sum_final;
   logic                last_new;

   tapa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tapa_mac u_mac (
      .op     (mac_op),
      .result (mac_result)
   );

   assign mac_over = mac_result > tapa_pkg::mac_word_type'(tapa_pkg::ADDR_LIMIT);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_source_offset = rsp_offset_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_error_code    = rsp_err_ff;

   // decode a restart: effective rank, permutation check, level axes and lengths
   always_comb begin
      logic [(2**tapa_pkg::AXIS_BITS)-1:0] seen;
      tapa_pkg::axis_type                  a;
      seen       = '0;
      bad_new    = 1'b0;
      first_last = 1'b1;
      if (cfg.rank == '0) begin
         rank_eff = tapa_pkg::rcnt_type'(1);
      end else if (cfg.rank > MR) begin
         rank_eff = tapa_pkg::rcnt_type'(MR);
      end else begin
         rank_eff = tapa_pkg::rcnt_type'(cfg.rank);
      end
      for (int k = 0; k < MR; k++) begin
         a           = cfg.order[tapa_pkg::AXIS_BITS*k +: tapa_pkg::AXIS_BITS];
         axes_new[k] = tapa_pkg::lvl_type'(k);
         len_new[k]  = tapa_pkg::dim_type'(1);
         if (k < rank_eff) begin
            if (a >= rank_eff || seen[a]) begin
               bad_new = 1'b1;
            end
            seen[a]     = 1'b1;
            axes_new[k] = (a < MR) ? tapa_pkg::lvl_type'(a) : '0;
            len_new[k]  = tapa_pkg::eff_dim(cfg.dim[axes_new[k]]);
            if (len_new[k] != tapa_pkg::dim_type'(1)) begin
               first_last = 1'b0;
            end
         end
      end
   end

   // odometer step, innermost level last
   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int j = MR - 1; j >= 0; j--) begin
         idx_step[j] = loop_index_ff[j];
         if (j < lat_rank_ff && carry) begin
            if (loop_index_ff[j] + 1 < lat_len_ff[j]) begin
               idx_step[j] = loop_index_ff[j] + tapa_pkg::dim_type'(1);
               carry       = 1'b0;
            end else begin
               idx_step[j] = '0;
            end
         end
      end
   end

   assign sum_final = (tapa_pkg::rcnt_type'(lvl_ff) + tapa_pkg::rcnt_type'(1)) == lat_rank_ff;
   assign last_new  = last_acc_ff && (loop_index_ff[lvl_ff] + 1 == lat_len_ff[lvl_ff]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tapa_pkg::ST_IDLE: begin
            if (accept && req_restart) begin
               state_in = tapa_pkg::ST_STRIDE;
            end else if (accept && pass_active_ff) begin
               state_in = tapa_pkg::ST_SUM;
            end
         end
         tapa_pkg::ST_STRIDE: begin
            if (lvl_ff == '0) begin
               state_in = tapa_pkg::ST_IDLE;
            end
         end
         tapa_pkg::ST_SUM: begin
            if (sum_final) begin
               state_in = tapa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tapa_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs: handshake and MAC operands
   always_comb begin
      req_stall = 1'b1;
      mac_op    = '0;
      case (state_ff)
         tapa_pkg::ST_IDLE: begin
            req_stall = !out_free;
         end
         tapa_pkg::ST_STRIDE: begin
            mac_op.a = prod_ff;
            mac_op.b = tapa_pkg::eff_dim(cfg.dim[lvl_ff]);
         end
         tapa_pkg::ST_SUM: begin
            mac_op.a = tapa_pkg::prod_type'(axis_stride_ff[lat_axis_ff[lvl_ff]]);
            mac_op.b = loop_index_ff[lvl_ff];
            mac_op.c = acc_ff;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      lvl_in         = lvl_ff;
      prod_in        = prod_ff;
      over_in        = over_ff;
      bad_in         = bad_ff;
      acc_in         = acc_ff;
      last_acc_in    = last_acc_ff;
      pass_active_in = pass_active_ff;
      lat_rank_in    = lat_rank_ff;
      lat_axis_in    = lat_axis_ff;
      lat_len_in     = lat_len_ff;
      loop_index_in  = loop_index_ff;
      axis_stride_in = axis_stride_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_offset_in  = rsp_offset_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_err_in     = rsp_err_ff;
      case (state_ff)
         tapa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_restart) begin
                  lvl_in         = tapa_pkg::lvl_type'(rank_eff - 1);
                  prod_in        = tapa_pkg::prod_type'(1);
                  over_in        = 1'b0;
                  bad_in         = bad_new;
                  last_acc_in    = first_last;
                  pass_active_in = 1'b0;
                  lat_rank_in    = rank_eff;
                  lat_axis_in    = axes_new;
                  lat_len_in     = len_new;
                  for (int k = 0; k < MR; k++) begin
                     loop_index_in[k] = '0;
                  end
               end else if (pass_active_ff) begin
                  loop_index_in = idx_step;
                  lvl_in        = '0;
                  acc_in        = '0;
                  last_acc_in   = 1'b1;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_offset_in = '0;
                  rsp_last_in   = 1'b0;
                  rsp_err_in    = tapa_pkg::ERR_OK;
               end
            end
         end
         tapa_pkg::ST_STRIDE: begin
            axis_stride_in[lvl_ff] = prod_ff[tapa_pkg::ADDR_BITS-1:0];
            prod_in = mac_over ? tapa_pkg::PROD_CLAMP : tapa_pkg::prod_type'(mac_result);
            over_in = over_ff || mac_over;
            lvl_in  = lvl_ff - tapa_pkg::lvl_type'(1);
            if (lvl_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = '0;
               rsp_last_in   = 1'b0;
               if (bad_ff) begin
                  rsp_err_in = tapa_pkg::ERR_PERM;
               end else if (over_ff || mac_over) begin
                  rsp_err_in = tapa_pkg::ERR_RANGE;
               end else begin
                  rsp_err_in     = tapa_pkg::ERR_OK;
                  rsp_last_in    = last_acc_ff;
                  pass_active_in = !last_acc_ff;
               end
            end
         end
         tapa_pkg::ST_SUM: begin
            acc_in      = mac_result[tapa_pkg::ADDR_BITS-1:0];
            last_acc_in = last_new;
            lvl_in      = lvl_ff + tapa_pkg::lvl_type'(1);
            if (sum_final) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = mac_result[tapa_pkg::ADDR_BITS-1:0];
               rsp_last_in   = last_new;
               rsp_err_in    = tapa_pkg::ERR_OK;
               if (last_new) begin
                  pass_active_in = 1'b0;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tapa_pkg::ST_IDLE;
         lvl_ff         <= '0;
         pass_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         lat_rank_ff    <= tapa_pkg::rcnt_type'(1);
         for (int k = 0; k < MR; k++) begin
            lat_axis_ff[k]    <= tapa_pkg::lvl_type'(k);
            lat_len_ff[k]     <= tapa_pkg::dim_type'(1);
            loop_index_ff[k]  <= '0;
            axis_stride_ff[k] <= tapa_pkg::addr_type'(1);
         end
      end else begin
         state_ff       <= state_in;
         lvl_ff         <= lvl_in;
         pass_active_ff <= pass_active_in;
         rsp_valid_ff   <= rsp_valid_in;
         lat_rank_ff    <= lat_rank_in;
         lat_axis_ff    <= lat_axis_in;
         lat_len_ff     <= lat_len_in;
         loop_index_ff  <= loop_index_in;
         axis_stride_ff <= axis_stride_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      over_ff       <= over_in;
      bad_ff        <= bad_in;
      acc_ff        <= acc_in;
      last_acc_ff   <= last_acc_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_err_ff    <= rsp_err_in;
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != tapa_pkg::ST_IDLE |-> req_stall)
      else $error("input taken while the sequencer is busy");

   a_work_output_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tapa_pkg::ST_STRIDE || state_ff == tapa_pkg::ST_SUM) |-> !rsp_valid_ff)
      else $error("result register occupied during a sequence");

   a_error_beat_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff != tapa_pkg::ERR_OK) |-> (!rsp_last_ff && rsp_offset_ff == '0))
      else $error("error beat carries offset or last");

   a_last_ends_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> !pass_active_ff)
      else $error("pass still active after its last beat");

endmodule

>>> design/tapa_mac.sv
// Shared multiply-accumulate unit for stride products and offset sums.
module tapa_mac (
   input  tapa_pkg::mac_op_type   op,
   output tapa_pkg::mac_word_type result
);

   tapa_pkg::mac_word_type prod;

   assign prod   = tapa_pkg::mac_word_type'(op.a) * tapa_pkg::mac_word_type'(op.b);
   assign result = prod + tapa_pkg::mac_word_type'(op.c);

endmodule

>>> design/tapa_csr.sv
// Configuration register file: rank, dimension sizes and axis order.
module tapa_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  tapa_pkg::csr_index_type csr_index,
   input  tapa_pkg::csr_data_type  csr_data,
   output tapa_pkg::cfg_type       cfg
);

   tapa_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == tapa_pkg::REG_RANK) begin
            cfg_in.rank = csr_data[tapa_pkg::RANK_BITS-1:0];
         end
         if (csr_index == tapa_pkg::REG_ORDER) begin
            cfg_in.order = csr_data[tapa_pkg::ORDER_BITS-1:0];
         end
         for (int k = 0; k < tapa_pkg::MAX_RANK; k++) begin
            if (k < tapa_pkg::NUM_DIM_REGS &&
                csr_index == tapa_pkg::csr_index_type'(int'(tapa_pkg::REG_DIM_0) + k)) begin
               cfg_in.dim[k] = csr_data[tapa_pkg::DIM_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= tapa_pkg::cfg_reset();
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
